FILE: rtl/pff_pkg.sv
// ============================================================================
// pff_pkg
// Shared types and constants for the Pareto front filter: point layout,
// opcode and controller state encodings, and the result word layout.
// ============================================================================
package pff_pkg;

   localparam int TAG_W      = 16;
   localparam int VAL_W      = 32;
   localparam int OP_W       = 2;
   localparam int COUNT_W    = 7;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 128;
   localparam int RSP_PAD_W  = RSP_DATA_W - (2 + COUNT_W + TAG_W + 3 * VAL_W);

   // request kinds carried on req_tuser
   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPEND,
      ST_RESP,
      ST_READ
   } state_type;

   // one stored point; iter_tag in the lowest bits, same as req_tdata
   typedef struct packed {
      logic [VAL_W-1:0] latency;
      logic [VAL_W-1:0] area;
      logic [VAL_W-1:0] aux_value;
      logic [TAG_W-1:0] iter_tag;
   } point_type;

   // outcome of comparing the new point against one stored point
   typedef struct packed {
      logic dominated;  // stored point no larger on both objectives
      logic covered;    // new point no larger on both objectives
   } cmp_type;

   // result word on rsp_tdata; kept in the lowest bit
   typedef struct packed {
      logic [RSP_PAD_W-1:0] pad;
      logic [VAL_W-1:0]     latency;
      logic [VAL_W-1:0]     area;
      logic [VAL_W-1:0]     aux_value;
      logic [TAG_W-1:0]     iter_tag;
      logic [COUNT_W-1:0]   front_count;
      logic                 overflow;
      logic                 kept;
   } rsp_data_type;

endpackage

FILE: rtl/pareto_front_filter.sv
// ============================================================================
// pareto_front_filter
// Keeps a non-dominated set of two-objective design points (area, latency,
// both minimized) in one on-chip memory. Supports insert, read-out and clear.
// ============================================================================
//
// Channel   Dir  Handshake              Contents
// req_*     in   req_tvalid/req_tready  tuser: op; tdata: point to insert
// rsp_*     out  rsp_tvalid/rsp_tready  tuser: entry_valid; tdata: status and
//                                       stored point; tlast: final result
//
// Sequence: an insert does one memory read per stored entry through the
// single read port, then an append, then a result. A read streams one
// result per stored point, holding while rsp_tready is low, or gives one
// status result on an empty set; clear and unused ops give one status
// result. One request is processed at a time.
// Reset clears the point count and the controller; memory contents are not
// cleared. A stalled result holds the walk in place; a new request is taken
// as soon as the previous one has placed its last result in the output
// register.
// ============================================================================
module pareto_front_filter #(
   parameter int FRONT_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   // request: tuser = op[1:0]
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // request: tdata = iter_tag[15:0], aux_value[47:16], area[79:48],
   //                  latency[111:80]
   input  logic [pff_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [pff_pkg::OP_W-1:0]       req_tuser,
   // result: tdata = kept[0], overflow[1], front_count[8:2],
   //                 out_iter_tag[24:9], out_aux_value[56:25],
   //                 out_area[88:57], out_latency[120:89], zero pad above
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [pff_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // result: tuser = entry_valid[0]
   output logic                           rsp_tuser,
   output logic                           rsp_tlast
);
   import pff_pkg::*;

   localparam int IDX_W = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1;
   localparam int CNT_W = $clog2(FRONT_DEPTH + 1);

   // point memory
   point_type            mem [FRONT_DEPTH];
   point_type            rd_data_ff;
   logic                 ren;
   logic [IDX_W-1:0]     raddr;
   logic                 wen;
   logic [IDX_W-1:0]     waddr;
   point_type            wdata;

   // control state
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     size_ff, size_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     w_ff, w_in;
   logic                 keep_ff, keep_in;
   logic                 ovf_ff, ovf_in;
   point_type            pt_ff, pt_in;

   // result register
   logic                 rsp_valid_ff;
   rsp_data_type         rsp_data_ff, rsp_data_in;
   logic                 rsp_user_ff, rsp_user_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_load;
   logic                 rsp_free;

   logic                 req_accept;
   op_type               req_op;
   cmp_type              cmp;
   logic [CNT_W-1:0]     idx_next_cnt;

   assign req_tready   = (state_ff == ST_IDLE);
   assign req_accept   = req_tvalid && req_tready;
   assign req_op       = op_type'(req_tuser);
   assign rsp_free     = !rsp_valid_ff || rsp_tready;
   assign idx_next_cnt = CNT_W'(idx_ff) + CNT_W'(1);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // dominance test of the held request against the entry just read
   pff_cmp u_cmp (
      .new_area    (pt_ff.area),
      .new_latency (pt_ff.latency),
      .old_area    (rd_data_ff.area),
      .old_latency (rd_data_ff.latency),
      .result      (cmp)
   );

   // next state, memory control and result load
   always_comb begin
      state_in    = state_ff;
      size_in     = size_ff;
      idx_in      = idx_ff;
      w_in        = w_ff;
      keep_in     = keep_ff;
      ovf_in      = ovf_ff;
      pt_in       = pt_ff;
      ren         = 1'b0;
      raddr       = idx_ff + IDX_W'(1);
      wen         = 1'b0;
      waddr       = w_ff[IDX_W-1:0];
      wdata       = rd_data_ff;
      rsp_load    = 1'b0;
      rsp_data_in = '0;
      rsp_user_in = 1'b0;
      rsp_last_in = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               pt_in   = point_type'(req_tdata);
               idx_in  = '0;
               w_in    = '0;
               keep_in = 1'b0;
               ovf_in  = 1'b0;
               raddr   = '0;
               case (req_op)
                  OP_INSERT: begin
                     keep_in = 1'b1;
                     if (size_ff == '0) begin
                        state_in = ST_APPEND;
                     end else begin
                        ren      = 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  OP_READ: begin
                     if (size_ff == '0) begin
                        state_in = ST_RESP;
                     end else begin
                        ren      = 1'b1;
                        state_in = ST_READ;
                     end
                  end
                  OP_CLEAR: begin
                     size_in  = '0;
                     state_in = ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         // walk the set, compacting survivors down to the write pointer;
         // an entry equal to the new point stays, since the new one is dropped
         ST_SCAN: begin
            if (cmp.dominated) begin
               keep_in = 1'b0;
            end
            if (!cmp.covered || cmp.dominated) begin
               wen  = 1'b1;
               w_in = w_ff + CNT_W'(1);
            end
            if (idx_next_cnt < size_ff) begin
               ren    = 1'b1;
               idx_in = idx_ff + IDX_W'(1);
            end else begin
               state_in = ST_APPEND;
            end
         end

         // place the new point behind the survivors, or flag a full set
         ST_APPEND: begin
            if (keep_ff) begin
               if (w_ff == CNT_W'(FRONT_DEPTH)) begin
                  ovf_in  = 1'b1;
                  size_in = w_ff;
               end else begin
                  wen     = 1'b1;
                  wdata   = pt_ff;
                  size_in = w_ff + CNT_W'(1);
               end
            end
            state_in = ST_RESP;
         end

         // single status result
         ST_RESP: begin
            if (rsp_free) begin
               rsp_load                = 1'b1;
               rsp_data_in.kept        = keep_ff;
               rsp_data_in.overflow    = ovf_ff;
               rsp_data_in.front_count = COUNT_W'(size_ff);
               state_in                = ST_IDLE;
            end
         end

         // stream stored points, one per accepted result slot
         ST_READ: begin
            if (rsp_free) begin
               rsp_load                = 1'b1;
               rsp_user_in             = 1'b1;
               rsp_data_in.front_count = COUNT_W'(size_ff);
               rsp_data_in.iter_tag    = rd_data_ff.iter_tag;
               rsp_data_in.aux_value   = rd_data_ff.aux_value;
               rsp_data_in.area        = rd_data_ff.area;
               rsp_data_in.latency     = rd_data_ff.latency;
               rsp_last_in             = (idx_next_cnt == size_ff);
               if (idx_next_cnt < size_ff) begin
                  ren    = 1'b1;
                  idx_in = idx_ff + IDX_W'(1);
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      w_ff    <= w_in;
      keep_ff <= keep_in;
      ovf_ff  <= ovf_in;
      pt_ff   <= pt_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   // point memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      if (ren) begin
         rd_data_ff <= mem[raddr];
      end
   end

   // count never exceeds capacity
   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      size_ff <= CNT_W'(FRONT_DEPTH))
      else $error("point count above capacity");

   // compaction write pointer never passes the read pointer
   a_w_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (w_ff <= CNT_W'(idx_ff)))
      else $error("compaction write pointer ahead of read");

   // clear empties the set
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_op == OP_CLEAR)) |=> (size_ff == '0))
      else $error("clear did not empty the set");

   // overflow only on a kept point, never on an entry result
   a_ovf_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.overflow |-> rsp_data_ff.kept && !rsp_user_ff)
      else $error("overflow without kept");

   // an entry result is only produced during a read walk
   a_entry_src: assert property (@(posedge clock) disable iff (reset)
      rsp_load && rsp_user_in |-> (state_ff == ST_READ))
      else $error("entry result outside read walk");

endmodule

FILE: rtl/pff_cmp.sv
// ============================================================================
// pff_cmp
// Dominance compare of the incoming point against one stored point, both
// objectives minimized. Flags both directions in one pass.
// ============================================================================
module pff_cmp (
   input  logic [pff_pkg::VAL_W-1:0] new_area,
   input  logic [pff_pkg::VAL_W-1:0] new_latency,
   input  logic [pff_pkg::VAL_W-1:0] old_area,
   input  logic [pff_pkg::VAL_W-1:0] old_latency,
   output pff_pkg::cmp_type          result
);
   import pff_pkg::*;

   logic area_ge;
   logic area_le;
   logic lat_ge;
   logic lat_le;

   // magnitude compares on each objective
   assign area_ge = (new_area >= old_area);
   assign area_le = (new_area <= old_area);
   assign lat_ge  = (new_latency >= old_latency);
   assign lat_le  = (new_latency <= old_latency);

   // stored point dominates or equals the new one / new one covers it
   assign result.dominated = area_ge && lat_ge;
   assign result.covered   = area_le && lat_le;

endmodule
